### hdl/assert_macros.svh
// Assertion macros for the verification checker module.
// The checker module that includes this file must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge while out of reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Expression that must never be true at a rising clock edge while out of reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

### hdl/rrhc_pkg.sv
// Shared types and constants for the RPC reply header checker.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package rrhc_pkg;

	localparam int DATA_W         = 32;
	localparam int CAP_W          = 14;
	localparam int BL_W           = 14;
	localparam int SKIP_W         = 12;
	localparam int STATUS_W       = 3;
	localparam int MAX_BODY_BYTES = 8192;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8192);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_MULTIFRAG = 3'd1,
		ST_TOOLONG   = 3'd2,
		ST_TRUNC     = 3'd3,
		ST_PROTO     = 3'd4,
		ST_REMOTE    = 3'd5
	} status_t;

	typedef struct packed {
		logic [DATA_W-1:0] reply_word;
		logic              start_of_message;
		logic [DATA_W-1:0] expected_xid;
	} in_item_t;

	typedef struct packed {
		logic              emit;
		status_t           status;
		logic [DATA_W-1:0] result_value;
		logic [DATA_W-1:0] remote_error;
	} parse_res_t;

endpackage

`default_nettype wire

### hdl/rrhc_in_stage.sv
// Input register of the RPC reply header checker: holds one request word.
// Depends on rrhc_pkg for the request payload type.
`default_nettype none

module rrhc_in_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire rrhc_pkg::in_item_t item,
	input  wire logic              commit,
	output logic                   valid_s1,
	output rrhc_pkg::in_item_t     item_s1
);

	logic load;

	assign in_ready = !valid_s1 || commit;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

endmodule

`default_nettype wire

### hdl/rrhc_parser.sv
// Reply parser of the RPC reply header checker: phase state machine, body
// byte and skip counters, saved fields and the capacity register. Uses rrhc_pkg.
`default_nettype none

module rrhc_parser (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write,
	input  wire logic [rrhc_pkg::CAP_W-1:0]    cfg_capacity,
	input  wire logic                          valid_s1,
	input  wire rrhc_pkg::in_item_t            item_s1,
	input  wire logic                          commit,
	output rrhc_pkg::parse_res_t               res
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_XID, PH_MTYPE, PH_RSTAT, PH_VFLAV,
		PH_VLEN, PH_VSKIP, PH_ASTAT, PH_RESULT, PH_ERR
	} phase_t;

	phase_t                            phase_q, phase_d, next_ph;
	logic [rrhc_pkg::BL_W-1:0]         bytes_q, bytes_d, bytes_m4;
	logic [rrhc_pkg::SKIP_W-1:0]       skip_q, skip_d, skip_dec;
	logic                              mism_q, mism_d;
	logic [rrhc_pkg::DATA_W-1:0]       sres_q, sres_d, sxid_q, sxid_d;
	logic [rrhc_pkg::CAP_W-1:0]        capacity_q;
	logic [rrhc_pkg::DATA_W-1:0]       cap32, len32, word;
	logic [rrhc_pkg::BL_W:0]           total;
	logic [1:0]                        pad;
	logic                              go_next;

	assign word     = item_s1.reply_word;
	assign bytes_m4 = bytes_q - rrhc_pkg::BL_W'(4);
	assign skip_dec = skip_q - rrhc_pkg::SKIP_W'(1);
	assign pad      = 2'(-word[1:0]);
	assign total    = {1'b0, word[rrhc_pkg::BL_W-1:0]} + (rrhc_pkg::BL_W+1)'(pad);
	assign len32    = {1'b0, word[30:0]};
	assign cap32    = (32'(capacity_q) > 32'(rrhc_pkg::MAX_BODY_BYTES)) ?
		32'(rrhc_pkg::MAX_BODY_BYTES) : 32'(capacity_q);

	always_comb begin
		phase_d          = phase_q;
		bytes_d          = bytes_q;
		skip_d           = skip_q;
		mism_d           = mism_q;
		sres_d           = sres_q;
		sxid_d           = sxid_q;
		next_ph          = PH_IDLE;
		go_next          = 1'b0;
		res.emit         = 1'b0;
		res.status       = rrhc_pkg::ST_OK;
		res.result_value = '0;
		res.remote_error = '0;
		if (item_s1.start_of_message) begin
			mism_d = 1'b0;
			sres_d = '0;
			skip_d = '0;
			sxid_d = item_s1.expected_xid;
			if (!word[31]) begin
				res.emit   = 1'b1;
				res.status = rrhc_pkg::ST_MULTIFRAG;
			end else if (len32 > cap32) begin
				res.emit   = 1'b1;
				res.status = rrhc_pkg::ST_TOOLONG;
			end else begin
				bytes_d = word[rrhc_pkg::BL_W-1:0];
				next_ph = PH_XID;
				go_next = 1'b1;
			end
		end else if (phase_q != PH_IDLE) begin
			bytes_d = bytes_m4;
			unique case (phase_q)
				PH_XID: begin
					if (word != sxid_q) mism_d = 1'b1;
					next_ph = PH_MTYPE;
					go_next = 1'b1;
				end
				PH_MTYPE: begin
					if (word != 32'd1) mism_d = 1'b1;
					next_ph = PH_RSTAT;
					go_next = 1'b1;
				end
				PH_RSTAT: begin
					if (mism_q || word != '0) begin
						mism_d     = 1'b1;
						res.emit   = 1'b1;
						res.status = rrhc_pkg::ST_PROTO;
					end else begin
						next_ph = PH_VFLAV;
						go_next = 1'b1;
					end
				end
				PH_VFLAV: begin
					if (word != '0) begin
						res.emit   = 1'b1;
						res.status = rrhc_pkg::ST_PROTO;
					end else begin
						next_ph = PH_VLEN;
						go_next = 1'b1;
					end
				end
				PH_VLEN: begin
					if (word[31:rrhc_pkg::BL_W] != '0 || total > {1'b0, bytes_m4}) begin
						res.emit   = 1'b1;
						res.status = rrhc_pkg::ST_TRUNC;
					end else begin
						skip_d = total[rrhc_pkg::SKIP_W+1:2];
						if (total[rrhc_pkg::SKIP_W+1:2] != '0) begin
							phase_d = PH_VSKIP;
						end else begin
							next_ph = PH_ASTAT;
							go_next = 1'b1;
						end
					end
				end
				PH_VSKIP: begin
					if (skip_q != '0) skip_d = skip_dec;
					if (skip_q != '0 && skip_dec != '0) begin
						phase_d = PH_VSKIP;
					end else begin
						next_ph = PH_ASTAT;
						go_next = 1'b1;
					end
				end
				PH_ASTAT: begin
					if (word != '0) begin
						res.emit   = 1'b1;
						res.status = rrhc_pkg::ST_PROTO;
					end else begin
						next_ph = PH_RESULT;
						go_next = 1'b1;
					end
				end
				PH_RESULT: begin
					sres_d  = word;
					next_ph = PH_ERR;
					go_next = 1'b1;
				end
				PH_ERR: begin
					res.emit = 1'b1;
					if (sres_q[31]) begin
						res.status       = rrhc_pkg::ST_REMOTE;
						res.remote_error = word;
					end else begin
						res.status       = rrhc_pkg::ST_OK;
						res.result_value = sres_q;
					end
				end
				default: begin
					bytes_d = bytes_q;
				end
			endcase
		end
		if (go_next) begin
			phase_d = next_ph;
			if (bytes_d < rrhc_pkg::BL_W'(4)) begin
				res.emit   = 1'b1;
				res.status = rrhc_pkg::ST_TRUNC;
			end
		end
		if (res.emit) begin
			phase_d = PH_IDLE;
		end
		if (!valid_s1) begin
			res.emit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			bytes_q    <= '0;
			skip_q     <= '0;
			mism_q     <= 1'b0;
			sres_q     <= '0;
			sxid_q     <= '0;
			capacity_q <= rrhc_pkg::CAP_RESET;
		end else begin
			if (cfg_write) begin
				capacity_q <= cfg_capacity;
			end
			if (commit) begin
				phase_q <= phase_d;
				bytes_q <= bytes_d;
				skip_q  <= skip_d;
				mism_q  <= mism_d;
				sres_q  <= sres_d;
				sxid_q  <= sxid_d;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/rrhc_out_stage.sv
// Result register of the RPC reply header checker with its valid flag.
// Depends on rrhc_pkg for the parser result type.
`default_nettype none

module rrhc_out_stage (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        load,
	input  wire rrhc_pkg::parse_res_t        res,
	output logic                             slot_free,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [rrhc_pkg::STATUS_W-1:0]    status,
	output logic [rrhc_pkg::DATA_W-1:0]      result_value,
	output logic [rrhc_pkg::DATA_W-1:0]      remote_error
);

	logic                           valid_q;
	rrhc_pkg::status_t              status_q;
	logic [rrhc_pkg::DATA_W-1:0]    result_q;
	logic [rrhc_pkg::DATA_W-1:0]    error_q;

	assign slot_free    = !valid_q || out_ready;
	assign out_valid    = valid_q;
	assign status       = status_q;
	assign result_value = result_q;
	assign remote_error = error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= res.status;
			result_q <= res.result_value;
			error_q  <= res.remote_error;
		end
	end

endmodule

`default_nettype wire

### hdl/rpc_reply_header_checker.sv
// Top level of the RPC reply header checker: input register, parser and
// result register. Depends on rrhc_pkg, rrhc_in_stage, rrhc_parser, rrhc_out_stage.
//
// Usage: reply words enter on the in channel (in_valid/in_ready), one
// request per word; a word with start_of_message set is the record marker
// and carries the expected_xid to match. Each reply yields exactly one
// request on the out channel (out_valid/out_ready) with status,
// result_value and remote_error; other words yield nothing.
// The capacity register is written through cfg_valid/cfg_ready with
// capacity_bytes as data; cfg_ready is always high, and writes belong
// between replies.
// A word accepted into the input register is parsed combinationally, and its
// result, if any, is loaded into the result register once that register is free.
// Throughput is one word per cycle while the result register is free, set by
// the single parser stage between the input register and the result register.
// When the receiver stalls, the result register holds its request and the
// input register holds one more word; in_ready drops only when that word
// would also produce a result.
// Reset empties both registers, returns the parser to waiting for a marker
// and sets the capacity to 8192 bytes.
`default_nettype none

module rpc_reply_header_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [rrhc_pkg::CAP_W-1:0]        capacity_bytes,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [rrhc_pkg::DATA_W-1:0]       reply_word,
	input  wire logic                              start_of_message,
	input  wire logic [rrhc_pkg::DATA_W-1:0]       expected_xid,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [rrhc_pkg::STATUS_W-1:0]          status,
	output logic signed [rrhc_pkg::DATA_W-1:0]     result_value,
	output logic [rrhc_pkg::DATA_W-1:0]            remote_error
);

	rrhc_pkg::in_item_t             item, item_s1;
	rrhc_pkg::parse_res_t           res;
	logic                           valid_s1, commit, slot_free;
	logic [rrhc_pkg::DATA_W-1:0]    result_raw;

	assign cfg_ready             = 1'b1;
	assign item.reply_word       = reply_word;
	assign item.start_of_message = start_of_message;
	assign item.expected_xid     = expected_xid;
	assign commit                = valid_s1 && (!res.emit || slot_free);
	assign result_value          = $signed(result_raw);

	rrhc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item     (item),
		.commit   (commit),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rrhc_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_valid && cfg_ready),
		.cfg_capacity (capacity_bytes),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1),
		.commit       (commit),
		.res          (res)
	);

	rrhc_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (commit && res.emit),
		.res          (res),
		.slot_free    (slot_free),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.result_value (result_raw),
		.remote_error (remote_error)
	);

endmodule

`default_nettype wire

### hdl/rrhc_checker.sv
// Port-level assertion checker for the RPC reply header checker, bound to the top level.
// Depends on rrhc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rrhc_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic [rrhc_pkg::DATA_W-1:0]       reply_word,
	input wire logic                              start_of_message,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic [rrhc_pkg::STATUS_W-1:0]     status,
	input wire logic signed [rrhc_pkg::DATA_W-1:0] result_value,
	input wire logic [rrhc_pkg::DATA_W-1:0]       remote_error
);

	logic stalled, ok_status, remote_status, frag_marker, frag_status;

	assign stalled       = out_valid && !out_ready;
	assign ok_status     = status == rrhc_pkg::ST_OK;
	assign remote_status = status == rrhc_pkg::ST_REMOTE;
	assign frag_marker   = in_valid && in_ready && start_of_message && !reply_word[31];
	assign frag_status   = out_valid && status == rrhc_pkg::ST_MULTIFRAG;

	`ASSERT_CLK(a_out_hold, stalled |=> out_valid && $stable(status) && $stable(result_value) && $stable(remote_error), "result request changed while stalled")
	`ASSERT_NEVER(a_value_only_ok, out_valid && !ok_status && result_value != '0, "result value on a failed reply")
	`ASSERT_NEVER(a_error_only_remote, out_valid && !remote_status && remote_error != '0, "remote error on a reply that is not a remote failure")
	`ASSERT_CLK(a_frag_reported, frag_marker ##1 (!out_valid || out_ready) |=> frag_status, "multi-fragment marker not reported")

endmodule

bind rpc_reply_header_checker rrhc_checker u_rrhc_checker (.*);

`default_nettype wire
